// ===== sv/tkds_pkg.sv =====
// Package for the top-K distinct selector: sizes, cell opcodes, control types.
// Standalone; used by tkds_cell and top_k_distinct_selector_core.
`default_nettype none

package tkds_pkg;

    localparam int MAX_K    = 64;
    localparam int CNT_W    = $clog2(MAX_K + 1);
    localparam int IDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int DATA_W   = 32;
    localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(10);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_SHL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REPORT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tkds_cell.sv =====
// One cell of the sorted chain: holds one value, compares it with a probe,
// and takes its left or right neighbor's value on insert or report shift.
// Depends on tkds_pkg.
`default_nettype none

module tkds_cell
    import tkds_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] probe,
    input  wire logic                     left_gt,
    input  wire logic signed [DATA_W-1:0] left_value,
    input  wire logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0]      value,
    output logic                          gt,
    output logic                          eq
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     gt_reg;
    logic                     gt_next;
    logic                     eq_reg;
    logic                     eq_next;

    always_comb
    begin
        value_next = value_reg;
        gt_next    = gt_reg;
        eq_next    = eq_reg;
        case (ctrl.op)
            CELL_CMP:
            begin
                gt_next = ctrl.occupied && (value_reg > probe);
                eq_next = ctrl.occupied && (value_reg == probe);
            end
            CELL_INS:
            begin
                // larger cells stay, first non-larger takes the probe, rest shift right
                if (!gt_reg)
                begin
                    value_next = left_gt ? probe : left_value;
                end
            end
            CELL_SHL:
            begin
                value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            gt_reg <= gt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ===== sv/top_k_distinct_selector_core.sv =====
// Top level of the top-K distinct selector: control sequencer, chain of
// MAX_K sorted cells, config register and registered result stage.
// Depends on tkds_pkg and tkds_cell.
//
//  channel  | signals                                   | dir | handshake
//  ---------+-------------------------------------------+-----+--------------
//  item     | item_valid item_stall value end_of_stream  | in  | valid/stall
//  result   | result_valid result_stall rank             | out | valid/stall
//           | selected_value last                        |     |
//  cfg      | cfg_valid cfg_ready cfg_data               | in  | valid/ready
//
// For each item, the cells compare against it on the accept edge, then the
// chain inserts it in parallel on the next one. An end-of-stream item then
// shifts the chain toward cell 0, one result beat per unstalled cycle, N beats
// for N reported values. Reset empties the store and sets keep_count to 10.
// Result stalls hold the output register and pause the report shift.
`default_nettype none

module top_k_distinct_selector_core
    import tkds_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     end_of_stream,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic [CNT_W-1:0]              rank,
    output logic signed [DATA_W-1:0]      selected_value,
    output logic                          last,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         cfg_data
);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         keep_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         total_reg;
    logic [CNT_W-1:0]         total_next;
    logic [CNT_W-1:0]         emit_reg;
    logic [CNT_W-1:0]         emit_next;
    logic signed [DATA_W-1:0] item_reg;
    logic                     eos_reg;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic [CNT_W-1:0]         rank_reg;
    logic signed [DATA_W-1:0] selected_reg;
    logic                     last_reg;

    logic [CNT_W-1:0]         eff_k;
    logic                     accept;
    logic                     dup;
    logic                     ins_go;
    logic                     room;
    logic [CNT_W-1:0]         limit;
    logic                     load;
    logic signed [DATA_W-1:0] probe;

    cell_ctrl_t               ctrl    [MAX_K];
    logic signed [DATA_W-1:0] cell_value [MAX_K];
    logic [MAX_K-1:0]         gt_vec;
    logic [MAX_K-1:0]         eq_vec;

    // keep_count of zero acts as 1, above MAX_K saturates
    always_comb
    begin
        if (keep_reg == '0)
        begin
            eff_k = CNT_W'(1);
        end
        else if (keep_reg > CNT_W'(MAX_K))
        begin
            eff_k = CNT_W'(MAX_K);
        end
        else
        begin
            eff_k = keep_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign probe      = (state_reg == ST_IDLE) ? value : item_reg;

    assign dup    = |eq_vec;
    assign room   = (count_reg < eff_k);
    // when full, the new value must beat the smallest held one
    assign ins_go = !dup && (room || !gt_vec[IDX_W'(count_reg - CNT_W'(1))]);
    assign limit  = room ? (count_reg + CNT_W'(1)) : count_reg;
    assign load   = (state_reg == ST_REPORT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            ctrl[i].occupied = (CNT_W'(i) < count_reg);
            case (state_reg)
                ST_IDLE:
                begin
                    ctrl[i].op = CELL_CMP;
                end
                ST_APPLY:
                begin
                    ctrl[i].op = (ins_go && (CNT_W'(i) < limit)) ? CELL_INS : CELL_HOLD;
                end
                ST_REPORT:
                begin
                    ctrl[i].op = load ? CELL_SHL : CELL_HOLD;
                end
                default:
                begin
                    ctrl[i].op = CELL_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < MAX_K; g++)
    begin : g_cell
        logic                     l_gt;
        logic signed [DATA_W-1:0] l_value;
        logic signed [DATA_W-1:0] r_value;

        if (g == 0)
        begin : g_head
            assign l_gt    = 1'b1;
            assign l_value = probe;
        end
        else
        begin : g_body
            assign l_gt    = gt_vec[g-1];
            assign l_value = cell_value[g-1];
        end

        if (g == MAX_K - 1)
        begin : g_tail
            assign r_value = cell_value[g];
        end
        else
        begin : g_mid
            assign r_value = cell_value[g+1];
        end

        tkds_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[g]),
            .probe       (probe),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .right_value (r_value),
            .value       (cell_value[g]),
            .gt          (gt_vec[g]),
            .eq          (eq_vec[g])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        total_next        = total_reg;
        emit_next         = emit_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (ins_go && room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (eos_reg)
                begin
                    total_next = (count_next < eff_k) ? count_next : eff_k;
                    emit_next  = '0;
                    count_next = '0;
                    state_next = ST_REPORT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                if (load)
                begin
                    result_valid_next = 1'b1;
                    emit_next         = emit_reg + CNT_W'(1);
                    if (emit_reg + CNT_W'(1) == total_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            keep_reg         <= KEEP_RESET;
            count_reg        <= '0;
            total_reg        <= '0;
            emit_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            total_reg        <= total_next;
            emit_reg         <= emit_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                keep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= value;
            eos_reg  <= end_of_stream;
        end
        if (load)
        begin
            rank_reg     <= emit_reg + CNT_W'(1);
            selected_reg <= cell_value[0];
            last_reg     <= (emit_reg + CNT_W'(1) == total_reg);
        end
    end

    assign result_valid   = result_valid_reg;
    assign rank           = rank_reg;
    assign selected_value = selected_reg;
    assign last           = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_K))
        else $error("held count above MAX_K");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (emit_reg < total_reg) && (total_reg != '0))
        else $error("report index out of range");

    a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_APPLY))
        else $error("accepted item not applied");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (rank_reg != '0) && (rank_reg <= CNT_W'(MAX_K)))
        else $error("result rank out of range");

endmodule

`default_nettype wire
